// File: hw/rtl/f2sf_pkg.sv
// Package with shared constants and types for the float to split fixed encoder.
`timescale 1ns / 1ps
package f2sf_pkg;
   localparam int FLOAT_W    = 32;
   localparam int HIGH_W     = 16;
   localparam int LOW_W      = 15;
   localparam int HIGH_MAG_W = 14;
   localparam int MAG_W      = 29;
   localparam int SIG_W      = 24;
   localparam logic [7:0] EXP_SPECIAL = 8'hff;
   localparam logic [7:0] EXP_ZERO    = 8'h00;
   // Exponent at which the significand lands unshifted in 1/512 units (150 - 9).
   localparam logic [7:0] EXP_ALIGN   = 8'd141;

   typedef struct packed {
      logic [HIGH_W-1:0] high_word;
      logic [LOW_W-1:0]  low_word;
   } result_type;
endpackage

// File: hw/rtl/float_to_split_fixed_encoder.sv
// Top level of the float to split sign-magnitude fixed-point encoder.
`timescale 1ns / 1ps
// One word is taken per clock: each accepted float pattern is registered,
// converted by shift and mask logic, and its result is shown on the rsp_
// ports for exactly one cycle. rsp_valid follows start through the input
// register and then the result register; busy is never asserted, so a new
// word may start in every cycle. The receiver cannot stall: every rsp_valid
// cycle carries a word that must be taken then. Magnitudes truncate toward
// zero in 1/512 units and wrap modulo 2^29; infinity, NaN, zero and
// subnormals give zero magnitude fields while the sign bit is always passed
// through.
module float_to_split_fixed_encoder import f2sf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [FLOAT_W-1:0] req_float_bits,
   output logic               rsp_valid,
   output logic [HIGH_W-1:0]  rsp_high_word,
   output logic [LOW_W-1:0]   rsp_low_word
);
   logic               in_valid_ff;
   logic [FLOAT_W-1:0] in_bits_ff;
   logic               out_valid_ff;
   result_type         out_ff;
   result_type         out_in;

   assign busy = 1'b0;

   f2sf_convert u_convert (
      .float_bits(in_bits_ff),
      .result    (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start;
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_bits_ff <= req_float_bits;
      out_ff     <= out_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_high_word = out_ff.high_word;
   assign rsp_low_word  = out_ff.low_word;
endmodule

// File: hw/rtl/f2sf_convert.sv
// Combinational conversion of one float bit pattern into the split fixed-point words.
`timescale 1ns / 1ps
module f2sf_convert import f2sf_pkg::*; (
   input  logic [FLOAT_W-1:0] float_bits,
   output result_type         result
);
   logic [7:0]       expo;
   logic [SIG_W-1:0] sig;
   logic [7:0]       left_amt;
   logic [7:0]       right_amt;
   logic [MAG_W-1:0] left_val;
   logic [SIG_W-1:0] right_val;
   logic [MAG_W-1:0] mag;

   assign expo      = float_bits[30:23];
   assign sig       = {1'b1, float_bits[22:0]};
   assign left_amt  = expo - EXP_ALIGN;
   assign right_amt = EXP_ALIGN - expo;
   assign left_val  = {{(MAG_W-SIG_W){1'b0}}, sig} << left_amt[4:0];
   assign right_val = sig >> right_amt[4:0];

   always_comb begin
      if (expo == EXP_SPECIAL || expo == EXP_ZERO) begin
         mag = '0;
      end else if (expo >= EXP_ALIGN) begin
         // Shifts of the full field width or more leave nothing in range.
         mag = (left_amt >= 8'(MAG_W)) ? '0 : left_val;
      end else begin
         mag = (right_amt >= 8'(SIG_W)) ? '0 : {{(MAG_W-SIG_W){1'b0}}, right_val};
      end
   end

   assign result.high_word = {1'b1, float_bits[31], mag[MAG_W-1:LOW_W]};
   assign result.low_word  = mag[LOW_W-1:0];
endmodule

// File: hw/rtl/f2sf_checker.sv
// Port-level assertions for the float to split fixed encoder, with their bind.
`timescale 1ns / 1ps
module f2sf_checker import f2sf_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [FLOAT_W-1:0] req_float_bits,
   input logic               rsp_valid,
   input logic [HIGH_W-1:0]  rsp_high_word,
   input logic [LOW_W-1:0]   rsp_low_word
);
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_valid) else $error("word not returned after two cycles");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2)) else $error("result without a started word");
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_high_word[HIGH_W-1]) else $error("high word marker missing");
   a_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_high_word[HIGH_W-2] == $past(req_float_bits[31], 2))
      else $error("sign bit mismatch");
endmodule

bind float_to_split_fixed_encoder f2sf_checker u_f2sf_checker (.*);
